FILE: src/dap_pkg.sv
// Shared types, constants and a helper function for the dihedral angle pipeline.
package dap_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_W = 20;
  localparam int VEC_W = 21;
  localparam int SQRT_STEPS = 32;
  localparam int CRD_W = 35;

  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    logic signed [31:0] qt;
    logic               neg;
  } side_t;

  typedef struct packed {
    logic zr;
    logic qneg;
    logic neg;
  } flag_t;

  // arctangent of 2^-i in units of 2^-32 turn, rounded
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // least k with (m >> k) <= 2^lim, saturating at 63
  function automatic logic [5:0] fit_shift(input logic [63:0] m, input int lim);
    logic [5:0] k;
    logic       found;
    k = 6'd63;
    found = 1'b0;
    for (int i = 0; i < 63; i++) begin
      if (!found && ((m >> i) <= (64'd1 << lim))) begin
        k = 6'(i);
        found = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

FILE: src/dap_pt_if.sv
// Input channel: four points per transaction.
interface dap_pt_if;
  logic valid;
  logic ready;
  logic signed [19:0] p1_x, p1_y, p1_z;
  logic signed [19:0] p2_x, p2_y, p2_z;
  logic signed [19:0] p3_x, p3_y, p3_z;
  logic signed [19:0] p4_x, p4_y, p4_z;
  modport source(output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                 p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
  modport sink(input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
               p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

FILE: src/dap_ang_if.sv
// Output channel: one torsion angle per transaction.
interface dap_ang_if;
  logic valid;
  logic ready;
  logic signed [15:0] dihedral;
  modport source(output valid, dihedral, input ready);
  modport sink(input valid, dihedral, output ready);
endinterface

FILE: src/dap_sqrt_cell.sv
// One digit step of the integer square root chain.
module dap_sqrt_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [63:0]    in_a,
  input  logic [63:0]    in_res,
  input  dap_pkg::side_t in_side,
  output logic           out_valid,
  output logic [63:0]    out_a,
  output logic [63:0]    out_res,
  output dap_pkg::side_t out_side
);
  localparam logic [63:0] B = 64'd1 << (2 * IDX);

  logic [63:0] trial;
  logic        take;

  assign trial = in_res + B;
  assign take  = in_a >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a    <= take ? in_a - trial : in_a;
      out_res  <= take ? (in_res >> 1) + B : in_res >> 1;
      out_side <= in_side;
    end
  end
endmodule

FILE: src/dap_cordic_cell.sv
// One vectoring micro-rotation of the arctangent chain.
module dap_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [dap_pkg::CRD_W-1:0]    in_x,
  input  logic signed [dap_pkg::CRD_W-1:0]    in_y,
  input  logic signed [dap_pkg::CRD_W-1:0]    in_z,
  input  dap_pkg::flag_t                      in_flag,
  output logic                                out_valid,
  output logic signed [dap_pkg::CRD_W-1:0]    out_x,
  output logic signed [dap_pkg::CRD_W-1:0]    out_y,
  output logic signed [dap_pkg::CRD_W-1:0]    out_z,
  output dap_pkg::flag_t                      out_flag
);
  localparam logic signed [dap_pkg::CRD_W-1:0] ANG =
    dap_pkg::CRD_W'({1'b0, dap_pkg::ATAN_TAB[IDX]});

  logic signed [dap_pkg::CRD_W-1:0] dx, dy;

  assign dx = in_y >>> IDX;
  assign dy = in_x >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_y > 0) begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + ANG;
      end else begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - ANG;
      end
      out_flag <= in_flag;
    end
  end
endmodule

FILE: src/dihedral_angle_four_points.sv
// Top level: torsion angle of four points as a binary angle.
//
//  channel | dir | payload                               | width
//  pt      | in  | p1_x..p4_z, four points, 1/256 A      | 12 x 20 signed
//  ang     | out | dihedral, 65536 units per turn        | 16 signed
//
// One transaction enters per cycle while ang is not stalled. Its path runs through
// eleven stages of vector arithmetic, 32 root cells, one pre-rotation stage,
// CORDIC_STEPS rotation cells and the output register. Synchronous reset
// clears only the valid bits. A stall on ang freezes the whole chain; pt.ready
// stays high while the output register is empty or being taken.
module dihedral_angle_four_points #(
  parameter int CORDIC_STEPS = dap_pkg::CORDIC_STEPS
) (
  input logic      clk,
  input logic      rst,
  dap_pt_if.sink   pt,
  dap_ang_if.source ang
);
  localparam int VW = dap_pkg::VEC_W;
  localparam int CW = dap_pkg::CRD_W;
  localparam int NS = dap_pkg::SQRT_STEPS;

  logic adv;
  logic ov;
  logic signed [15:0] dout;
  logic [11:1] fv;

  // advance whenever the output register is free or being drained
  assign adv = !ov || ang.ready;
  assign pt.ready = adv;
  assign ang.valid = ov;
  assign ang.dihedral = dout;

  logic signed [19:0] p [12];
  assign p[0]  = pt.p1_x;  assign p[1]  = pt.p1_y;  assign p[2]  = pt.p1_z;
  assign p[3]  = pt.p2_x;  assign p[4]  = pt.p2_y;  assign p[5]  = pt.p2_z;
  assign p[6]  = pt.p3_x;  assign p[7]  = pt.p3_y;  assign p[8]  = pt.p3_z;
  assign p[9]  = pt.p4_x;  assign p[10] = pt.p4_y;  assign p[11] = pt.p4_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (adv) begin
      fv <= {fv[10:1], pt.valid};
    end
  end

  // stage registers of the vector front end
  dap_pkg::vec_t      ab1 [3], bc1 [3], cd1 [3];
  logic signed [41:0] qa2 [3], qb2 [3], ta2 [3], tb2 [3];
  dap_pkg::vec_t      bc2 [3], bc3 [3], bc4 [3], bc5 [3], bc6 [3], bc7 [3], bc8 [3];
  logic signed [42:0] q3 [3], t3 [3], q4 [3], t4 [3];
  logic [5:0]         kq4, kt4, k8;
  dap_pkg::vec_t      qs5 [3], ts5 [3];
  logic signed [41:0] sp6 [3], sn6 [3], qp6 [3];
  logic signed [41:0] s7 [3], s8 [3];
  logic signed [41:0] qt7, qt8;
  logic signed [45:0] lo8 [3];
  logic signed [38:0] hi8 [3];
  logic signed [31:0] ss9 [3];
  logic signed [31:0] qt9, qt10, qt11;
  logic               neg9, neg10, neg11;
  logic [61:0]        sq10 [3];
  logic [63:0]        sum11;

  logic [63:0] magq, magt, mags;
  logic signed [63:0] sbc;
  logic [30:0] amag [3];

  always_comb begin
    magq = '0;
    magt = '0;
    for (int c = 0; c < 3; c++) begin
      magq = magq | 64'(q3[c] < 0 ? -q3[c] : q3[c]);
      magt = magt | 64'(t3[c] < 0 ? -t3[c] : t3[c]);
    end
  end

  always_comb begin
    mags = 64'(qt7 < 0 ? -qt7 : qt7);
    for (int c = 0; c < 3; c++) begin
      mags = mags | 64'(s7[c] < 0 ? -s7[c] : s7[c]);
    end
  end

  always_comb begin
    sbc = '0;
    for (int c = 0; c < 3; c++) begin
      sbc = sbc + (64'(hi8[c]) <<< 24) + 64'(lo8[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      amag[c] = ss9[c] < 0 ? 31'(-ss9[c]) : 31'(ss9[c]);
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_vec
    localparam int I1 = (c + 1) % 3;
    localparam int I2 = (c + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        // bond vectors
        ab1[c] <= VW'(p[3 + c]) - VW'(p[c]);
        bc1[c] <= VW'(p[6 + c]) - VW'(p[3 + c]);
        cd1[c] <= VW'(p[9 + c]) - VW'(p[6 + c]);
        // cross product terms of the two normals
        qa2[c] <= ab1[I1] * bc1[I2];
        qb2[c] <= bc1[I1] * ab1[I2];
        ta2[c] <= bc1[I1] * cd1[I2];
        tb2[c] <= cd1[I1] * bc1[I2];
        bc2[c] <= bc1[c];
        q3[c]  <= 43'(qa2[c]) - 43'(qb2[c]);
        t3[c]  <= 43'(ta2[c]) - 43'(tb2[c]);
        bc3[c] <= bc2[c];
        q4[c]  <= q3[c];
        t4[c]  <= t3[c];
        bc4[c] <= bc3[c];
        // scale normals to 21-bit signed values, magnitude at most 2^19
        qs5[c] <= VW'(q4[c] >>> kq4);
        ts5[c] <= VW'(t4[c] >>> kt4);
        bc5[c] <= bc4[c];
        sp6[c] <= qs5[I1] * ts5[I2];
        sn6[c] <= ts5[I1] * qs5[I2];
        qp6[c] <= qs5[c] * ts5[c];
        bc6[c] <= bc5[c];
        s7[c]  <= sp6[c] - sn6[c];
        bc7[c] <= bc6[c];
        // split S so each product for the sign test stays narrow
        lo8[c] <= $signed({1'b0, s7[c][23:0]}) * bc7[c];
        hi8[c] <= $signed(s7[c][41:24]) * bc7[c];
        s8[c]  <= s7[c];
        bc8[c] <= bc7[c];
        ss9[c] <= 32'(s8[c] >>> k8);
        sq10[c] <= 62'(amag[c]) * 62'(amag[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kq4   <= dap_pkg::fit_shift(magq, 19);
      kt4   <= dap_pkg::fit_shift(magt, 19);
      qt7   <= qp6[0] + qp6[1] + qp6[2];
      qt8   <= qt7;
      k8    <= dap_pkg::fit_shift(mags, 30);
      qt9   <= 32'(qt8 >>> k8);
      neg9  <= sbc < 0;
      qt10  <= qt9;
      neg10 <= neg9;
      qt11  <= qt10;
      neg11 <= neg10;
      sum11 <= 64'(sq10[0]) + 64'(sq10[1]) + 64'(sq10[2]);
    end
  end

  // integer square root, one result bit per cell
  logic           sv [NS+1];
  logic [63:0]    sa [NS+1];
  logic [63:0]    sr [NS+1];
  dap_pkg::side_t sd [NS+1];

  assign sv[0] = fv[11];
  assign sa[0] = sum11;
  assign sr[0] = '0;
  assign sd[0] = '{qt: qt11, neg: neg11};

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    dap_sqrt_cell #(.IDX(NS - 1 - j)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(sv[j]), .in_a(sa[j]), .in_res(sr[j]), .in_side(sd[j]),
      .out_valid(sv[j+1]), .out_a(sa[j+1]), .out_res(sr[j+1]), .out_side(sd[j+1])
    );
  end

  // pre-rotation by a quarter turn when Q.T is negative
  logic                 cv [CORDIC_STEPS+1];
  logic signed [CW-1:0] cx [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy [CORDIC_STEPS+1];
  logic signed [CW-1:0] cz [CORDIC_STEPS+1];
  dap_pkg::flag_t       cf [CORDIC_STEPS+1];
  logic [31:0]          r;

  assign r = sr[NS][31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= sv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sd[NS].qt < 0) begin
        cx[0] <= CW'({1'b0, r});
        cy[0] <= -CW'(sd[NS].qt);
        cz[0] <= CW'(32'h40000000);
      end else begin
        cx[0] <= CW'(sd[NS].qt);
        cy[0] <= CW'({1'b0, r});
        cz[0] <= '0;
      end
      cf[0] <= '{zr: r == '0, qneg: sd[NS].qt < 0, neg: sd[NS].neg};
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    dap_cordic_cell #(.IDX(j)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(cv[j]), .in_x(cx[j]), .in_y(cy[j]), .in_z(cz[j]), .in_flag(cf[j]),
      .out_valid(cv[j+1]), .out_x(cx[j+1]), .out_y(cy[j+1]), .out_z(cz[j+1]),
      .out_flag(cf[j+1])
    );
  end

  // round to 16 bits, handle a zero root, apply the sign of S.BC
  logic signed [CW-1:0] zr;
  logic [15:0]          base;

  assign zr = cz[CORDIC_STEPS] + CW'(32'h8000);

  always_comb begin
    if (cf[CORDIC_STEPS].zr) begin
      base = cf[CORDIC_STEPS].qneg ? 16'h8000 : 16'h0000;
    end else begin
      base = zr[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= cf[CORDIC_STEPS].neg ? $signed(16'h0000 - base) : $signed(base);
    end
  end
endmodule

FILE: tb/dihedral_angle_four_points_tb.sv
// Self-checking testbench for the four-point torsion angle pipeline.
module dihedral_angle_four_points_tb;

  // Twelve coordinates of one transaction, index 3*point + axis.
  typedef logic [11:0][19:0] quad_t;

  localparam int N_RANDOM = 1400;
  localparam int DRAIN_CYCLES = 45 + dap_pkg::CORDIC_STEPS + 40;

  logic clk;
  logic rst;

  dap_pt_if  pt ();
  dap_ang_if ang ();

  dihedral_angle_four_points dut (
    .clk(clk),
    .rst(rst),
    .pt (pt.sink),
    .ang(ang.source)
  );

  quad_t        pending_q[$];   // quadruples still to be offered
  logic [15:0]  angle_q[$];     // predicted angles, oldest first
  int           errors = 0;
  int unsigned  cyc = 0;
  bit           taken = 1'b0;   // a transaction went in at the last rising edge
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_mode = 0;
  int           mode_left = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, what,
             $signed(got), $signed(want));
    errors++;
  endtask

  function automatic longint floor_shift(input longint v, input int k);
    return v >>> k;
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // least shift that brings every magnitude in the OR-ed mask to at most 2^lim
  function automatic int norm_shift(input logic [63:0] m, input int lim);
    int k;
    k = 0;
    while (k < 63 && (m >> k) > (64'd1 << lim)) k++;
    return k;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] a);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      b = 64'd1 << (2 * i);
      if (a >= res + b) begin
        a = a - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // vectoring CORDIC: atan2(y, x) for y >= 0 in units of 2^-32 turn
  function automatic longint vector_angle(input longint x, input longint y);
    longint z;
    longint t;
    longint dx;
    longint dy;
    int     n;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'h40000000;
    end
    n = dap_pkg::CORDIC_STEPS > 32 ? 32 : dap_pkg::CORDIC_STEPS;
    for (int i = 0; i < n; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += longint'(dap_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(dap_pkg::ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] torsion_angle(input quad_t p);
    longint      c[12];
    longint      ab[3], bc[3], cd[3], q[3], t[3], s[4];
    longint      qt, sbc, ang_full;
    logic [63:0] m, ss, r;
    logic [15:0] res;
    int          k;
    for (int i = 0; i < 12; i++) c[i] = longint'($signed(p[i]));
    for (int i = 0; i < 3; i++) begin
      ab[i] = c[3 + i] - c[i];
      bc[i] = c[6 + i] - c[3 + i];
      cd[i] = c[9 + i] - c[6 + i];
    end
    q[0] = ab[1] * bc[2] - bc[1] * ab[2];
    q[1] = ab[2] * bc[0] - bc[2] * ab[0];
    q[2] = ab[0] * bc[1] - bc[0] * ab[1];
    t[0] = bc[1] * cd[2] - cd[1] * bc[2];
    t[1] = bc[2] * cd[0] - cd[2] * bc[0];
    t[2] = bc[0] * cd[1] - cd[0] * bc[1];
    m = mag(q[0]) | mag(q[1]) | mag(q[2]);
    k = norm_shift(m, 19);
    for (int i = 0; i < 3; i++) q[i] = floor_shift(q[i], k);
    m = mag(t[0]) | mag(t[1]) | mag(t[2]);
    k = norm_shift(m, 19);
    for (int i = 0; i < 3; i++) t[i] = floor_shift(t[i], k);
    s[0] = q[1] * t[2] - t[1] * q[2];
    s[1] = q[2] * t[0] - t[2] * q[0];
    s[2] = q[0] * t[1] - t[0] * q[1];
    s[3] = q[0] * t[0] + q[1] * t[1] + q[2] * t[2];
    sbc = s[0] * bc[0] + s[1] * bc[1] + s[2] * bc[2];
    m = mag(s[0]) | mag(s[1]) | mag(s[2]) | mag(s[3]);
    k = norm_shift(m, 30);
    for (int i = 0; i < 4; i++) s[i] = floor_shift(s[i], k);
    qt = s[3];
    ss = 64'(mag(s[0]) * mag(s[0])) + 64'(mag(s[1]) * mag(s[1]))
       + 64'(mag(s[2]) * mag(s[2]));
    r = int_sqrt(ss);
    if (r == 0) begin
      // on the axis: cis gives zero, trans gives pi exactly
      res = qt < 0 ? 16'h8000 : 16'h0000;
    end else begin
      ang_full = floor_shift(vector_angle(qt, longint'(r)) + 64'h8000, 16);
      res = ang_full[15:0];
    end
    if (sbc < 0) res = 16'(-res);
    return res;
  endfunction

  function automatic logic [19:0] spread(input int r);
    return 20'($signed($urandom_range(0, 2 * r)) - r);
  endfunction

  function automatic quad_t make_quad(input int base[12]);
    quad_t p;
    for (int i = 0; i < 12; i++) p[i] = 20'(base[i]);
    return p;
  endfunction

  // Random content: mostly chain-like geometry, some fully random points.
  function automatic quad_t random_quad();
    quad_t p;
    int    sel;
    int    reach;
    int    origin[3];
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      for (int i = 0; i < 12; i++) p[i] = 20'($urandom);
    end else begin
      reach = sel < 8 ? 512 : (sel == 8 ? 8 : 65536);
      for (int a = 0; a < 3; a++) origin[a] = $signed($urandom_range(0, 800000)) - 400000;
      for (int i = 0; i < 12; i++)
        p[i] = 20'(origin[i % 3] + (i / 3) * 200 + $signed(spread(reach)));
    end
    return p;
  endfunction

  // Fill the stimulus queue: corner geometries first, then random quadruples.
  initial begin
    pending_q.push_back(make_quad('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    pending_q.push_back(make_quad('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 256, 0}));
    pending_q.push_back(make_quad('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, -256, 0}));
    pending_q.push_back(make_quad('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 0, 256}));
    pending_q.push_back(make_quad('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 0, -256}));
    pending_q.push_back(make_quad('{-256, 0, 0, 0, 0, 0, 256, 0, 0, 512, 0, 0}));
    pending_q.push_back(make_quad('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 256, 1}));
    pending_q.push_back(make_quad('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, -256, 1}));
    pending_q.push_back(make_quad('{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, -256, -1}));
    pending_q.push_back(make_quad('{5, 5, 5, 5, 5, 5, 9, 9, 9, 1, 2, 3}));
    pending_q.push_back(make_quad('{-524288, -524288, -524288, 524287, 524287, 524287,
                                    -524288, 524287, -524288, 524287, -524288, 524287}));
    pending_q.push_back(make_quad('{524287, -524288, 524287, -524288, 524287, -524288,
                                    524287, 524287, -524288, -524288, -524288, 524287}));
    pending_q.push_back(make_quad('{-524288, 0, 0, 0, 524287, 0, 0, 0, 524287,
                                    524287, -524288, -524288}));
    pending_q.push_back(make_quad('{524287, 524287, 524287, -524288, -524288, -524288,
                                    524287, -524288, 524287, -524288, 524287, 524287}));
    pending_q.push_back(make_quad('{0, 1, 0, 0, 0, 0, 1, 0, 0, 1, 1, 0}));
    pending_q.push_back(make_quad('{0, 1, 0, 0, 0, 0, 1, 0, 0, 1, -1, 0}));
    pending_q.push_back(make_quad('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}));
    for (int n = 0; n < N_RANDOM; n++) pending_q.push_back(random_quad());
  end

  // Reset, drain and verdict.
  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0);
    wait (angle_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("dihedral_angle_four_points verification clean");
    end else begin
      $display("dihedral_angle_four_points verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("dihedral_angle_four_points verification failed");
    $finish;
  end

  // Driver: change inputs on the falling edge. Hold a transaction that was
  // offered but not taken; otherwise advance through bursts and gaps.
  always @(negedge clk) begin
    if (rst) begin
      pt.valid <= 1'b0;
      pt.p1_x <= '0; pt.p1_y <= '0; pt.p1_z <= '0;
      pt.p2_x <= '0; pt.p2_y <= '0; pt.p2_z <= '0;
      pt.p3_x <= '0; pt.p3_y <= '0; pt.p3_z <= '0;
      pt.p4_x <= '0; pt.p4_y <= '0; pt.p4_z <= '0;
    end else if (!(pt.valid && !taken)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0 && burst_left == 0) begin
        gap_left--;
        pt.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        burst_left--;
        pt.valid <= 1'b1;
        pt.p1_x <= pending_q[0][0];  pt.p1_y <= pending_q[0][1];  pt.p1_z <= pending_q[0][2];
        pt.p2_x <= pending_q[0][3];  pt.p2_y <= pending_q[0][4];  pt.p2_z <= pending_q[0][5];
        pt.p3_x <= pending_q[0][6];  pt.p3_y <= pending_q[0][7];  pt.p3_z <= pending_q[0][8];
        pt.p4_x <= pending_q[0][9];  pt.p4_y <= pending_q[0][10]; pt.p4_z <= pending_q[0][11];
      end else begin
        pt.valid <= 1'b0;
      end
    end
  end

  // Receiver: drop ready on a pattern that changes now and then, with
  // phases of no stalling at all.
  always @(negedge clk) begin
    if (rst) begin
      ang.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (stall_mode)
        0: begin
          ang.ready <= 1'b1;
        end
        1: begin
          ang.ready <= (cyc % 7 != 3) && (cyc % 11 != 5);
        end
        2: begin
          ang.ready <= (cyc % 16) < 5;
        end
        default: begin
          ang.ready <= $urandom_range(0, 9) < 7;
        end
      endcase
    end
  end

  // Monitor: sample both channels on the rising edge.
  always @(posedge clk) begin
    cyc++;
    taken = 1'b0;
    if (!rst && pt.valid && pt.ready) begin
      angle_q.push_back(torsion_angle(pending_q[0]));
      void'(pending_q.pop_front());
      taken = 1'b1;
    end
    if (!rst && ang.valid && ang.ready) begin
      if (angle_q.size() == 0) begin
        report("unexpected dihedral", ang.dihedral, 16'h0000);
      end else begin
        if (ang.dihedral !== angle_q[0]) report("dihedral", ang.dihedral, angle_q[0]);
        void'(angle_q.pop_front());
      end
    end
  end

endmodule
